@@ hdl/bgrc_pkg.sv @@
package bgrc_pkg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EMIT = 4'b0100,
        S_STAT = 4'b1000
    } state_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] bits;
        logic [1:0] digits;
    } radix_entry_t;

    localparam logic [1:0] REG_RADIX     = 2'd0;
    localparam logic [1:0] REG_DIRECTION = 2'd1;
    localparam logic [1:0] REG_LIMIT     = 2'd2;

    localparam logic DIR_TO_DIGITS = 1'b0;
    localparam logic DIR_TO_BITS   = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_RADIX  = 3'd1;
    localparam logic [2:0] ST_BIT_COUNT  = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_BAD_DIGIT  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;
    localparam logic [2:0] ST_LIMIT      = 3'd6;

    // bits per group and digits per group for each supported base
    function automatic radix_entry_t radix_lookup(input logic [4:0] k);
        radix_entry_t e;
        e = '{ok: 1'b0, bits: 3'd0, digits: 2'd0};
        unique case (k)
            5'd2:    e = '{ok: 1'b1, bits: 3'd1, digits: 2'd1};
            5'd3:    e = '{ok: 1'b1, bits: 3'd3, digits: 2'd2};
            5'd4:    e = '{ok: 1'b1, bits: 3'd2, digits: 2'd1};
            5'd5:    e = '{ok: 1'b1, bits: 3'd2, digits: 2'd1};
            5'd6:    e = '{ok: 1'b1, bits: 3'd5, digits: 2'd2};
            5'd8:    e = '{ok: 1'b1, bits: 3'd3, digits: 2'd1};
            5'd12:   e = '{ok: 1'b1, bits: 3'd7, digits: 2'd2};
            5'd16:   e = '{ok: 1'b1, bits: 3'd4, digits: 2'd1};
            default: e = '{ok: 1'b0, bits: 3'd0, digits: 2'd0};
        endcase
        return e;
    endfunction

endpackage

@@ hdl/bit_group_radix_converter.sv @@
// A request's results leave through a registered output; when the group needs two digits,
//   an 8-step restoring divider (one quotient bit per cycle) runs before the first result.
// A new request is taken only when idle, once every result of the last has been sent (a final
//   request with no data gives one status-only result); one result per cycle while m_ready is high.
// Reset (aresetn low, synchronous): radix 2, direction 0, bit limit 0, message state
//   cleared, no result pending.
module bit_group_radix_converter #(
    parameter int COUNT_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_symbol_in,
    input  logic       s_last_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_symbol_out,
    output logic       m_symbol_valid,
    output logic       m_last_out,
    output logic [2:0] m_status
);
    import bgrc_pkg::*;

    localparam int W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    state_t state_reg, state_next;

    logic [4:0]  radix_reg;
    logic        dir_reg;
    logic [15:0] limit_reg;

    logic [7:0]            gv_reg, gv_next;
    logic [2:0]            pos_reg, pos_next;
    logic [2:0]            bmod_reg, bmod_next;
    logic [COUNT_BITS-1:0] be_reg, be_next;
    logic [2:0]            err_reg, err_next;

    logic [7:0] work_reg, work_next;
    logic [3:0] rem_reg, rem_next;
    logic [2:0] div_cnt_reg, div_cnt_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       bits_mode_reg, bits_mode_next;
    logic       last_reg, last_next;

    logic       m_valid_reg, m_valid_next;
    logic [3:0] m_symbol_reg, m_symbol_next;
    logic       m_symval_reg, m_symval_next;
    logic       m_last_reg, m_last_next;
    logic [2:0] m_status_reg, m_status_next;

    radix_entry_t lk;
    logic         accept, out_free;
    logic         bit0, bad0, bad1;
    logic [3:0]   dig1;
    logic [7:0]   gv0, gv1, v0;
    logic [2:0]   pos_inc, shamt;
    logic [12:0]  prod;
    logic         fire0, fire1, ovf, err_set4;
    logic [W-1:0] be_ext, lim_ext, max_ext, diff;
    logic [2:0]   keep;
    logic [COUNT_BITS:0] be_sum;
    logic [COUNT_BITS-1:0] be_sat;
    logic [2:0]   status;
    logic [4:0]   trial, trial_sub;
    logic         ge;
    logic [7:0]   quot;
    logic [3:0]   emit_sym;

    assign lk       = radix_lookup(radix_reg);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_symbol_out   = m_symbol_reg;
    assign m_symbol_valid = m_symval_reg;
    assign m_last_out     = m_last_reg;
    assign m_status       = m_status_reg;

    // bits -> digits path
    assign bad0    = (s_symbol_in > 4'd1);
    assign bit0    = (s_symbol_in == 4'd1);
    assign gv0     = {gv_reg[6:0], bit0};
    assign pos_inc = pos_reg + 3'd1;
    assign fire0   = lk.ok && ((pos_inc >= lk.bits) || (s_last_in && (pos_inc != 3'd0)));
    assign shamt   = lk.bits - pos_inc;
    assign v0      = (pos_inc < lk.bits) ? 8'(gv0 << shamt) : gv0;

    // digits -> bits path
    assign bad1  = ({1'b0, s_symbol_in} >= radix_reg);
    assign dig1  = bad1 ? 4'd0 : s_symbol_in;
    assign prod  = gv_reg * radix_reg;
    assign gv1   = prod[7:0] + {4'd0, dig1};
    assign fire1 = lk.ok && (pos_inc >= {1'b0, lk.digits});
    assign ovf   = ((gv1 >> lk.bits) != 8'd0);

    assign err_set4 = (dir_reg == DIR_TO_DIGITS) ? bad0 : (lk.ok && bad1);

    // how many of the group's bits fall under the limit (kept bits form a prefix)
    assign be_ext  = W'(be_reg);
    assign lim_ext = W'(limit_reg);
    assign max_ext = W'({COUNT_BITS{1'b1}});
    assign diff    = lim_ext - be_ext;
    always_comb begin
        if (be_ext >= lim_ext) begin
            keep = 3'd0;
        end else if (max_ext < lim_ext) begin
            keep = lk.bits;
        end else if (diff < W'(lk.bits)) begin
            keep = diff[2:0];
        end else begin
            keep = lk.bits;
        end
    end

    assign be_sum = {1'b0, be_reg} + (COUNT_BITS+1)'(lk.bits);
    assign be_sat = be_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : be_sum[COUNT_BITS-1:0];

    // final status from message state as left by the current request
    always_comb begin
        if (!lk.ok) begin
            status = ST_BAD_RADIX;
        end else if (dir_reg == DIR_TO_DIGITS && bmod_reg != 3'd0) begin
            status = ST_BIT_COUNT;
        end else if (dir_reg == DIR_TO_BITS && limit_reg[2:0] != 3'd0) begin
            status = ST_BIT_COUNT;
        end else if (dir_reg == DIR_TO_BITS && pos_reg != 3'd0) begin
            status = ST_INCOMPLETE;
        end else if (err_reg != ST_OK) begin
            status = err_reg;
        end else if (dir_reg == DIR_TO_BITS && lim_ext > be_ext) begin
            status = ST_LIMIT;
        end else begin
            status = ST_OK;
        end
    end

    // restoring divide step; remainder stays below radix
    assign trial     = {rem_reg, work_reg[7]};
    assign ge        = (trial >= radix_reg);
    assign trial_sub = ge ? (trial - radix_reg) : trial;
    assign quot      = {work_reg[6:0], ge};

    assign emit_sym = bits_mode_reg ? {3'd0, work_reg[7]} : work_reg[7:4];

    always_comb begin
        state_next     = state_reg;
        gv_next        = gv_reg;
        pos_next       = pos_reg;
        bmod_next      = bmod_reg;
        be_next        = be_reg;
        err_next       = err_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        cnt_next       = cnt_reg;
        bits_mode_next = bits_mode_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_symbol_next  = m_symbol_reg;
        m_symval_next  = m_symval_reg;
        m_last_next    = m_last_reg;
        m_status_next  = m_status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    last_next = s_last_in;
                    cnt_next  = 3'd0;
                    if (err_reg == ST_OK) begin
                        if (err_set4) begin
                            err_next = ST_BAD_DIGIT;
                        end else if (dir_reg == DIR_TO_BITS && fire1 && ovf) begin
                            err_next = ST_OVERFLOW;
                        end
                    end
                    if (dir_reg == DIR_TO_DIGITS) begin
                        bmod_next      = bmod_reg + 3'd1;
                        bits_mode_next = 1'b0;
                        if (lk.ok) begin
                            if (fire0) begin
                                gv_next  = 8'd0;
                                pos_next = 3'd0;
                                if (lk.digits == 2'd2) begin
                                    work_next    = v0;
                                    rem_next     = 4'd0;
                                    div_cnt_next = 3'd7;
                                    cnt_next     = 3'd2;
                                end else begin
                                    work_next = {v0[3:0], 4'd0};
                                    cnt_next  = 3'd1;
                                end
                            end else begin
                                gv_next  = gv0;
                                pos_next = pos_inc;
                            end
                        end
                    end else if (lk.ok) begin
                        bits_mode_next = 1'b1;
                        if (fire1) begin
                            gv_next   = 8'd0;
                            pos_next  = 3'd0;
                            be_next   = be_sat;
                            work_next = 8'(gv1 << (4'd8 - {1'b0, lk.bits}));
                            cnt_next  = keep;
                        end else begin
                            gv_next  = gv1;
                            pos_next = pos_inc;
                        end
                    end

                    if (dir_reg == DIR_TO_DIGITS && fire0 && lk.digits == 2'd2) begin
                        state_next = S_DIV;
                    end else if (dir_reg == DIR_TO_DIGITS && fire0) begin
                        state_next = S_EMIT;
                    end else if (dir_reg == DIR_TO_BITS && fire1 && keep != 3'd0) begin
                        state_next = S_EMIT;
                    end else if (s_last_in) begin
                        state_next = S_STAT;
                    end
                end
            end

            S_DIV: begin
                div_cnt_next = div_cnt_reg - 3'd1;
                if (div_cnt_reg == 3'd0) begin
                    work_next  = {quot[3:0], trial_sub[3:0]};
                    state_next = S_EMIT;
                end else begin
                    work_next = quot;
                    rem_next  = trial_sub[3:0];
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = emit_sym;
                    m_symval_next = 1'b1;
                    m_last_next   = last_reg && (cnt_reg == 3'd1);
                    m_status_next = (last_reg && cnt_reg == 3'd1) ? status : ST_OK;
                    work_next     = bits_mode_reg ? {work_reg[6:0], 1'b0}
                                                  : {work_reg[3:0], 4'd0};
                    cnt_next      = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1) begin
                        state_next = S_IDLE;
                        if (last_reg) begin
                            gv_next   = 8'd0;
                            pos_next  = 3'd0;
                            bmod_next = 3'd0;
                            be_next   = '0;
                            err_next  = ST_OK;
                        end
                    end
                end
            end

            S_STAT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = 4'd0;
                    m_symval_next = 1'b0;
                    m_last_next   = 1'b1;
                    m_status_next = status;
                    gv_next       = 8'd0;
                    pos_next      = 3'd0;
                    bmod_next     = 3'd0;
                    be_next       = '0;
                    err_next      = ST_OK;
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            radix_reg   <= 5'd2;
            dir_reg     <= DIR_TO_DIGITS;
            limit_reg   <= 16'd0;
            gv_reg      <= 8'd0;
            pos_reg     <= 3'd0;
            bmod_reg    <= 3'd0;
            be_reg      <= '0;
            err_reg     <= ST_OK;
            cnt_reg     <= 3'd0;
            div_cnt_reg <= 3'd0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gv_reg      <= gv_next;
            pos_reg     <= pos_next;
            bmod_reg    <= bmod_next;
            be_reg      <= be_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
            div_cnt_reg <= div_cnt_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_RADIX:     radix_reg <= cfg_wdata[4:0];
                    REG_DIRECTION: dir_reg   <= cfg_wdata[0];
                    REG_LIMIT:     limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        bits_mode_reg <= bits_mode_next;
        m_symbol_reg  <= m_symbol_next;
        m_symval_reg  <= m_symval_next;
        m_last_reg    <= m_last_next;
        m_status_reg  <= m_status_next;
    end

endmodule

@@ dv/tb_bit_group_radix_converter.sv @@
`timescale 1ns / 100ps

module tb_bit_group_radix_converter;
    import bgrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 190;
    localparam int REPORT_CAP     = 40;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [3:0] symbol;
        logic       sym_valid;
        logic       is_last;
        logic [2:0] status;
    } conv_result_t;

    // Tracks the converter's message state and the results each request should produce.
    class radix_scoreboard;
        logic [4:0]  cfg_radix;
        logic        cfg_dir;
        logic [15:0] cfg_limit;

        logic [7:0]  acc;
        logic [2:0]  acc_pos;
        logic [2:0]  bit_phase;
        logic [15:0] bits_out;
        logic [2:0]  err_code;

        conv_result_t expected_q[$];
        int errors;
        int requests;
        int results;
        int messages;

        function new();
            cfg_radix = 5'd2;
            cfg_dir   = DIR_TO_DIGITS;
            cfg_limit = 16'd0;
            errors    = 0;
            requests  = 0;
            results   = 0;
            messages  = 0;
            clear_message();
        endfunction

        function void clear_message();
            acc       = 8'd0;
            acc_pos   = 3'd0;
            bit_phase = 3'd0;
            bits_out  = 16'd0;
            err_code  = ST_OK;
        endfunction

        function bit group_shape(input int k, output int nbits, output int ndig);
            nbits = 0;
            ndig  = 0;
            case (k)
                2:  begin nbits = 1; ndig = 1; end
                3:  begin nbits = 3; ndig = 2; end
                4:  begin nbits = 2; ndig = 1; end
                5:  begin nbits = 2; ndig = 1; end
                6:  begin nbits = 5; ndig = 2; end
                8:  begin nbits = 3; ndig = 1; end
                12: begin nbits = 7; ndig = 2; end
                16: begin nbits = 4; ndig = 1; end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_RADIX:     cfg_radix = data[4:0];
                REG_DIRECTION: cfg_dir   = data[0];
                REG_LIMIT:     cfg_limit = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function conv_result_t data_result(int s);
            conv_result_t r;
            r.symbol    = s[3:0];
            r.sym_valid = 1'b1;
            r.is_last   = 1'b0;
            r.status    = ST_OK;
            return r;
        endfunction

        function void note_request(logic [3:0] sym_in, logic last_in);
            conv_result_t batch[$];
            conv_result_t r;
            int nbits, ndig, k, sym, v, i, t;
            int digits[2];
            bit ok;
            logic [2:0] st;
            sym = sym_in;
            k = cfg_radix;
            ok = group_shape(k, nbits, ndig);
            requests++;
            if (cfg_dir == DIR_TO_DIGITS) begin
                // a bit above 1 counts as a bad digit and enters as 0
                if (sym > 1) begin
                    if (err_code == ST_OK) err_code = ST_BAD_DIGIT;
                    sym = 0;
                end
                bit_phase = bit_phase + 3'd1;
                if (ok) begin
                    acc = {acc[6:0], sym[0]};
                    acc_pos = acc_pos + 3'd1;
                    if (acc_pos >= nbits || (last_in && acc_pos > 0)) begin
                        if (acc_pos < nbits) acc = acc << (nbits - int'(acc_pos));
                        v = acc;
                        for (i = ndig - 1; i > 0; i--) begin
                            digits[i] = v % k;
                            v = v / k;
                        end
                        digits[0] = v;
                        for (i = 0; i < ndig; i++)
                            batch.insert(batch.size(), data_result(digits[i]));
                        acc = 8'd0;
                        acc_pos = 3'd0;
                    end
                end
            end else if (ok) begin
                if (sym >= k) begin
                    if (err_code == ST_OK) err_code = ST_BAD_DIGIT;
                    sym = 0;
                end
                acc = 8'(int'(acc) * k + sym);
                acc_pos = acc_pos + 3'd1;
                if (acc_pos >= ndig) begin
                    if ((acc >> nbits) != 0 && err_code == ST_OK) err_code = ST_OVERFLOW;
                    for (t = nbits; t > 0; t--) begin
                        if (bits_out < cfg_limit)
                            batch.insert(batch.size(), data_result(acc[t - 1]));
                        if (bits_out != 16'hFFFF) bits_out = bits_out + 16'd1;
                    end
                    acc = 8'd0;
                    acc_pos = 3'd0;
                end
            end

            if (last_in) begin
                if (!ok) st = ST_BAD_RADIX;
                else if (cfg_dir == DIR_TO_DIGITS && bit_phase != 0) st = ST_BIT_COUNT;
                else if (cfg_dir == DIR_TO_BITS && cfg_limit[2:0] != 0) st = ST_BIT_COUNT;
                else if (cfg_dir == DIR_TO_BITS && acc_pos != 0) st = ST_INCOMPLETE;
                else if (err_code != ST_OK) st = err_code;
                else if (cfg_dir == DIR_TO_BITS && cfg_limit > bits_out) st = ST_LIMIT;
                else st = ST_OK;
                if (batch.size() == 0) begin
                    r = data_result(0);
                    r.sym_valid = 1'b0;
                    batch.insert(batch.size(), r);
                end
                r = batch.pop_back();
                r.is_last = 1'b1;
                r.status  = st;
                batch.insert(batch.size(), r);
                clear_message();
                messages++;
            end
            foreach (batch[j]) expected_q.insert(expected_q.size(), batch[j]);
        endfunction

        function void report(string field, int want, int got);
            errors++;
            if (errors <= REPORT_CAP)
                $error("result %0d: %s expected %0d, got %0d", results, field, want, got);
        endfunction

        function void check_result(logic [3:0] sym, logic sv, logic lst, logic [2:0] st);
            conv_result_t want;
            results++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $error("result %0d arrived with nothing expected", results);
                return;
            end
            want = expected_q.pop_front();
            if (sym !== want.symbol)    report("symbol_out", want.symbol, sym);
            if (sv  !== want.sym_valid) report("symbol_valid", want.sym_valid, sv);
            if (lst !== want.is_last)   report("last_out", want.is_last, lst);
            if (st  !== want.status)    report("status", want.status, st);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_symbol_in = 4'd0;
    logic        s_last_in = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_symbol_out;
    logic        m_symbol_valid;
    logic        m_last_out;
    logic [2:0]  m_status;

    radix_scoreboard sb;
    int send_idle = 37;
    int recv_idle = 70;
    int items_sent = 0;
    int settings_used = 0;
    int stall_cycles = 0;
    logic [3:0] msg_q[$];
    int base_list[8] = '{2, 3, 4, 5, 6, 8, 12, 16};

    bit_group_radix_converter i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol_in    (s_symbol_in),
        .s_last_in      (s_last_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol_out   (m_symbol_out),
        .m_symbol_valid (m_symbol_valid),
        .m_last_out     (m_last_out),
        .m_status       (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_request(s_symbol_in, s_last_in);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_symbol_out, m_symbol_valid, m_last_out, m_status);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(logic [3:0] sym, logic lst);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_symbol_in <= sym;
        s_last_in   <= lst;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_queue(bit ends);
        foreach (msg_q[i]) send_item(msg_q[i], ends && (i == msg_q.size() - 1));
        msg_q.delete();
    endtask

    // each hex nibble is one symbol, most significant first
    task automatic load_hex(logic [63:0] h, int count);
        for (int i = count - 1; i >= 0; i--) msg_q.insert(msg_q.size(), h[4 * i +: 4]);
    endtask

    // no request in flight and no result outstanding
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(int k, logic dir, logic [15:0] lim);
        wait_idle();
        program_reg(REG_RADIX, 16'(k));
        program_reg(REG_DIRECTION, {15'd0, dir});
        program_reg(REG_LIMIT, lim);
        settings_used++;
    endtask

    task automatic random_message();
        int nbits, ndig, k, len, groups, kind, v;
        bit ok;
        k = sb.cfg_radix;
        ok = sb.group_shape(k, nbits, ndig);
        if (sb.cfg_dir == DIR_TO_DIGITS) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 20) : 8 * $urandom_range(1, 3);
            repeat (len) begin
                if ($urandom_range(19) == 0)
                    msg_q.insert(msg_q.size(), 4'($urandom_range(15)));
                else
                    msg_q.insert(msg_q.size(), 4'($urandom_range(1)));
            end
        end else if (!ok) begin
            repeat ($urandom_range(1, 6)) msg_q.insert(msg_q.size(), 4'($urandom_range(15)));
        end else begin
            if (sb.cfg_limit <= 40)
                groups = (int'(sb.cfg_limit) + nbits - 1) / nbits + $urandom_range(1);
            else
                groups = $urandom_range(1, 4);
            if (groups == 0) groups = 1;
            kind = $urandom_range(9);
            repeat (groups) begin
                if (kind == 0) begin
                    // raw digits: out of range and group overflow
                    repeat (ndig) msg_q.insert(msg_q.size(), 4'($urandom_range(15)));
                end else begin
                    v = $urandom_range((1 << nbits) - 1);
                    if (ndig == 2) begin
                        msg_q.insert(msg_q.size(), 4'(v / k));
                        msg_q.insert(msg_q.size(), 4'(v % k));
                    end else begin
                        msg_q.insert(msg_q.size(), 4'(v));
                    end
                end
            end
            if (kind == 1) begin
                if (ndig == 2) msg_q.insert(msg_q.size(), 4'($urandom_range(k - 1)));
                else if (msg_q.size() > 1) void'(msg_q.pop_back());
            end
        end
        send_queue(1'b1);
    endtask

    initial begin
        int random_start, k, lim, done;
        logic dir;
        sb = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // radix 12 with a bad bit in a zero-padded final group
        apply_settings(12, DIR_TO_DIGITS, 16'd0);
        load_hex(64'h1011011F, 8);
        send_queue(1'b1);
        // unsupported base, status-only result; unused register index is ignored
        apply_settings(31, DIR_TO_DIGITS, 16'd0);
        program_reg(REG_UNUSED, 16'($urandom));
        load_hex(64'h1, 1);
        send_queue(1'b1);
        // group overflow first, then a digit at or above the base
        apply_settings(3, DIR_TO_BITS, 16'd8);
        load_hex(64'h223100, 6);
        send_queue(1'b1);
        apply_settings(6, DIR_TO_BITS, 16'd8);
        load_hex(64'h5, 1);
        send_queue(1'b1);
        apply_settings(16, DIR_TO_BITS, 16'd16);
        load_hex(64'hF, 1);
        send_queue(1'b1);
        apply_settings(16, DIR_TO_BITS, 16'hFFFF);
        load_hex(64'hF, 1);
        send_queue(1'b1);
        apply_settings(2, DIR_TO_BITS, 16'd0);
        load_hex(64'h1, 1);
        send_queue(1'b1);
        // base switched between requests of one message
        apply_settings(8, DIR_TO_DIGITS, 16'd0);
        load_hex(64'h11, 2);
        send_queue(1'b0);
        wait_idle();
        program_reg(REG_RADIX, 16'd4);
        load_hex(64'h1, 1);
        send_queue(1'b1);

        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            done = items_sent - random_start;
            if (done < RANDOM_ITEMS / 3) begin
                send_idle = 37;
                recv_idle = 70;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_idle = 70;
                recv_idle = 37;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            k = ($urandom_range(9) == 0) ? $urandom_range(31) : base_list[$urandom_range(7)];
            dir = 1'($urandom_range(1));
            if (dir == DIR_TO_DIGITS) begin
                lim = $urandom_range(65535);
            end else begin
                case ($urandom_range(9))
                    0:       lim = 0;
                    1:       lim = 65535;
                    2:       lim = $urandom_range(1, 40);
                    default: lim = 8 * $urandom_range(1, 3);
                endcase
            end
            apply_settings(k, dir, 16'(lim));
            repeat ($urandom_range(1, 3)) random_message();
        end

        wait_idle();
        $display("Ran %0d messages (%0d requests, %0d results) over %0d register settings,",
                 sb.messages, sb.requests, sb.results, settings_used);
        $display("both directions, all table bases and unsupported ones, with and without stalls.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
